### rtl/sequence_pattern_deleter_assert.svh
// Assertion macros for the sequence pattern deleter checker.
// Included by the checker; every macro samples on clock and is disabled in reset.
`ifndef SEQUENCE_PATTERN_DELETER_ASSERT_SVH
`define SEQUENCE_PATTERN_DELETER_ASSERT_SVH

// Same-cycle implication.
`define SPD_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("spd assertion failed");

// Next-cycle implication.
`define SPD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("spd assertion failed");

`endif

### rtl/spd_pkg.sv
// Shared types, register codes and constants of the sequence pattern deleter.
// No dependencies; every other RTL module uses it.
`default_nettype none

package spd_pkg;

   localparam int unsigned PATTERN_MAX_DEF = 4;
   localparam int unsigned WordCount       = 4;
   localparam int unsigned WordIdxW        = 2;
   localparam int unsigned CountW          = 3;
   localparam int unsigned AddrW           = 5;
   localparam int unsigned DataW           = 32;

   typedef logic signed [31:0] spd_word_type;

   typedef enum logic [2:0] {
      REG_PATTERN_LENGTH = 3'd0,
      REG_PATTERN_WORD_0 = 3'd1,
      REG_PATTERN_WORD_1 = 3'd2,
      REG_PATTERN_WORD_2 = 3'd3,
      REG_PATTERN_WORD_3 = 3'd4
   } spd_reg_type;

   typedef struct packed {
      spd_word_type element_value;
      logic         stream_end;
   } spd_req_type;

   typedef struct packed {
      spd_word_type kept_value;
      logic         run_last;
      logic         sequence_done;
   } spd_rsp_type;

   typedef struct packed {
      logic [CountW-1:0]                pattern_length;
      spd_word_type [WordCount-1:0]     pattern_word;
   } spd_cfg_type;

   // Results produced by one item: how many, and whether it closes the stream.
   typedef struct packed {
      logic [CountW-1:0] count;
      logic              stream_end;
   } spd_bundle_ctl_type;

endpackage

`default_nettype wire

### rtl/spd_csr.sv
// APB-style register file: pattern length and the four pattern words.
// Depends on spd_pkg.
`default_nettype none

module spd_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [spd_pkg::AddrW-1:0]    csr_paddr,
   input  logic [spd_pkg::DataW-1:0]    csr_pwdata,
   output logic [spd_pkg::DataW-1:0]    csr_prdata,
   output logic                         csr_pready,
   output spd_pkg::spd_cfg_type         cfg
);
   import spd_pkg::*;

   spd_cfg_type cfg_ff, cfg_in;
   logic [2:0]  reg_idx;
   logic        wr_en;

   assign reg_idx    = csr_paddr[AddrW-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_PATTERN_LENGTH: cfg_in.pattern_length  = csr_pwdata[CountW-1:0];
            REG_PATTERN_WORD_0: cfg_in.pattern_word[0] = csr_pwdata;
            REG_PATTERN_WORD_1: cfg_in.pattern_word[1] = csr_pwdata;
            REG_PATTERN_WORD_2: cfg_in.pattern_word[2] = csr_pwdata;
            REG_PATTERN_WORD_3: cfg_in.pattern_word[3] = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_PATTERN_LENGTH: csr_prdata = {{(DataW-CountW){1'b0}}, cfg_ff.pattern_length};
         REG_PATTERN_WORD_0: csr_prdata = cfg_ff.pattern_word[0];
         REG_PATTERN_WORD_1: csr_prdata = cfg_ff.pattern_word[1];
         REG_PATTERN_WORD_2: csr_prdata = cfg_ff.pattern_word[2];
         REG_PATTERN_WORD_3: csr_prdata = cfg_ff.pattern_word[3];
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_length <= CountW'(1);
         cfg_ff.pattern_word   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

### rtl/spd_match.sv
// Match engine: match count, held values and the list of results for one item.
// Depends on spd_pkg.
`default_nettype none

module spd_match #(
   parameter int unsigned PATTERN_MAX = spd_pkg::PATTERN_MAX_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  spd_pkg::spd_cfg_type         cfg,
   input  spd_pkg::spd_req_type         item,
   input  logic                         advance,
   output spd_pkg::spd_word_type        slot_val [PATTERN_MAX],
   output spd_pkg::spd_bundle_ctl_type  bundle_ctl
);
   import spd_pkg::*;

   localparam int unsigned HeldDepth = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
   localparam int unsigned HeldIdxW  = (HeldDepth > 1) ? $clog2(HeldDepth) : 1;

   logic [CountW-1:0]   match_count_ff, match_count_in;
   spd_word_type        held_ff [HeldDepth];

   logic [CountW-1:0]   eff_len;
   logic                hit_cur;
   logic                hit_first;
   logic                full_match;
   logic                single;
   logic [CountW-1:0]   flush_count;
   logic                keep_value;
   logic                held_we;
   logic [HeldIdxW-1:0] held_idx;

   always_comb begin
      if (cfg.pattern_length == '0) begin
         eff_len = CountW'(1);
      end else if (cfg.pattern_length > CountW'(PATTERN_MAX)) begin
         eff_len = CountW'(PATTERN_MAX);
      end else begin
         eff_len = cfg.pattern_length;
      end
   end

   assign hit_cur    = (match_count_ff < eff_len) &&
                       (item.element_value == cfg.pattern_word[match_count_ff[WordIdxW-1:0]]);
   assign hit_first  = (item.element_value == cfg.pattern_word[0]);
   assign full_match = ((match_count_ff + CountW'(1)) == eff_len);
   assign single     = (eff_len == CountW'(1));

   always_comb begin
      if (hit_cur) begin
         // extend the match, drop the whole occurrence, or flush it all at end of stream
         flush_count    = (item.stream_end && !full_match) ? match_count_ff : '0;
         keep_value     = item.stream_end && !full_match;
         match_count_in = (full_match || item.stream_end) ? '0
                                                          : match_count_ff + CountW'(1);
         held_we        = !full_match;
         held_idx       = match_count_ff[HeldIdxW-1:0];
      end else begin
         // emit held values, then retry the value as the start of a new match
         flush_count    = match_count_ff;
         keep_value     = !hit_first || (!single && item.stream_end);
         match_count_in = (hit_first && !single && !item.stream_end) ? CountW'(1) : '0;
         held_we        = hit_first && !single;
         held_idx       = '0;
      end
   end

   always_comb begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
         slot_val[j] = item.element_value;
      end
      for (int j = 0; j < HeldDepth; j++) begin
         if (CountW'(j) < flush_count) begin
            slot_val[j] = held_ff[j];
         end
      end
   end

   assign bundle_ctl.count      = flush_count + CountW'(keep_value);
   assign bundle_ctl.stream_end = item.stream_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_count_ff <= '0;
      end else if (advance) begin
         match_count_ff <= match_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && held_we) begin
         held_ff[held_idx] <= item.element_value;
      end
   end

endmodule

`default_nettype wire

### rtl/spd_out.sv
// Result register: holds the results of one item and hands them out one a cycle while rsp_ready is high.
// Depends on spd_pkg.
`default_nettype none

module spd_out #(
   parameter int unsigned PATTERN_MAX = spd_pkg::PATTERN_MAX_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  spd_pkg::spd_word_type        slot_val [PATTERN_MAX],
   input  spd_pkg::spd_bundle_ctl_type  bundle_ctl,
   output logic                         can_load,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output spd_pkg::spd_rsp_type         rsp_payload
);
   import spd_pkg::*;

   localparam int unsigned SlotW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

   spd_word_type     vals_ff [PATTERN_MAX];
   logic             valid_ff, valid_in;
   logic [SlotW-1:0] ptr_ff, ptr_in;
   logic [SlotW-1:0] last_ff, last_in;
   logic             end_ff, end_in;
   logic             at_last;
   logic             finishing;
   logic             take;
   logic [CountW-1:0] last_wide;

   assign at_last   = (ptr_ff == last_ff);
   assign finishing = valid_ff && rsp_ready && at_last;
   assign can_load  = !valid_ff || finishing;
   assign take      = load && (bundle_ctl.count != '0);
   assign last_wide = bundle_ctl.count - CountW'(1);

   always_comb begin
      valid_in = valid_ff;
      ptr_in   = ptr_ff;
      last_in  = last_ff;
      end_in   = end_ff;
      if (take) begin
         valid_in = 1'b1;
         ptr_in   = '0;
         last_in  = last_wide[SlotW-1:0];
         end_in   = bundle_ctl.stream_end;
      end else if (finishing) begin
         valid_in = 1'b0;
      end else if (valid_ff && rsp_ready) begin
         ptr_in = ptr_ff + SlotW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         ptr_ff   <= '0;
         last_ff  <= '0;
         end_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         ptr_ff   <= ptr_in;
         last_ff  <= last_in;
         end_ff   <= end_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         for (int j = 0; j < PATTERN_MAX; j++) begin
            vals_ff[j] <= slot_val[j];
         end
      end
   end

   assign rsp_valid                 = valid_ff;
   assign rsp_payload.kept_value    = vals_ff[ptr_ff];
   assign rsp_payload.run_last      = at_last;
   assign rsp_payload.sequence_done = at_last && end_ff;

endmodule

`default_nettype wire

### rtl/sequence_pattern_deleter.sv
// Sequence pattern deleter: removes every complete occurrence of a configured
// pattern of 1 to PATTERN_MAX signed 32-bit values from a stream. Values that
// match a prefix of the pattern are held back and emitted in order on a
// mismatch or at end of stream; a full match drops them. Each transaction
// passes an input register, the match engine and a result register. One
// transaction is taken per cycle while the output does not stall, as long as
// each gives at most one result; a transaction that gives n results (n up to
// PATTERN_MAX) holds the result register and hands them out one result per
// cycle while rsp_ready is high, and one more transaction waits in the input
// register meanwhile. Transactions with no result skip the result register.
// Depends on spd_pkg, spd_csr, spd_match and spd_out.
`default_nettype none

module sequence_pattern_deleter #(
   parameter int unsigned PATTERN_MAX = spd_pkg::PATTERN_MAX_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  spd_pkg::spd_req_type       req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output spd_pkg::spd_rsp_type       rsp_payload,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [spd_pkg::AddrW-1:0]  csr_paddr,
   input  logic [spd_pkg::DataW-1:0]  csr_pwdata,
   output logic [spd_pkg::DataW-1:0]  csr_prdata,
   output logic                       csr_pready
);
   import spd_pkg::*;

   spd_cfg_type        cfg;
   spd_req_type        item_ff;
   logic               item_valid_ff, item_valid_in;
   logic               advance;
   logic               can_load;
   logic               req_fire;
   spd_word_type       slot_val [PATTERN_MAX];
   spd_bundle_ctl_type bundle_ctl;

   spd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // advance the held item into the match engine when the result register frees up
   assign advance       = item_valid_ff && can_load;
   assign req_ready     = !item_valid_ff || advance;
   assign req_fire      = req_valid && req_ready;
   assign item_valid_in = req_fire || (item_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= req_payload;
      end
   end

   spd_match #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_match (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item       (item_ff),
      .advance    (advance),
      .slot_val   (slot_val),
      .bundle_ctl (bundle_ctl)
   );

   spd_out #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_out (
      .clock       (clock),
      .reset       (reset),
      .load        (advance),
      .slot_val    (slot_val),
      .bundle_ctl  (bundle_ctl),
      .can_load    (can_load),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

### rtl/spd_checker.sv
// Port-level checker for the sequence pattern deleter, bound to the top level.
// Depends on spd_pkg and sequence_pattern_deleter_assert.svh.
`default_nettype none

`include "sequence_pattern_deleter_assert.svh"

module spd_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input spd_pkg::spd_rsp_type       rsp_payload
);
   // with no result pending the block always has room for a transaction
   `SPD_ASSERT_IMP(a_ready_when_drained, !rsp_valid, req_ready)

   // a result that is not the last of its run is followed by another one
   `SPD_ASSERT_NEXT(a_run_continues, rsp_valid && rsp_ready && !rsp_payload.run_last, rsp_valid)

   // end of sequence only ever closes a run
   `SPD_ASSERT_IMP(a_done_closes_run, rsp_valid && rsp_payload.sequence_done, rsp_payload.run_last)

   // a stalled result holds
   `SPD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

endmodule

bind sequence_pattern_deleter spd_checker u_spd_checker (.*);

`default_nettype wire
